### hw/rtl/fpfa_pkg.sv
// shared constants and codes for the fixed partition fit allocator
package fpfa_pkg;

  localparam int FPFA_PARTITIONS = 8;
  localparam int FPFA_SIZE_BITS  = 16;

  localparam int SLOT_W     = 3;
  localparam int BYTES_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int MODE_W     = 2;
  localparam int PCOUNT_W   = 4;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  localparam logic [MODE_W-1:0] MODE_FIRST    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'd1;

  localparam logic [MODE_W-1:0]   FIT_MODE_RESET   = MODE_BEST;
  localparam logic [PCOUNT_W-1:0] PART_COUNT_RESET = 4'd8;

endpackage

### hw/rtl/fixed_partition_fit_allocator.sv
// fixed partition allocator top level: config, sequencer, scan compare, result register
// load item: in_ready stays high
// request: slots below lim are read from the size memory and compared in order, lim = min(partition_count, PARTITIONS);
// first fit with its hit at slot k stops early
// in_ready is low from a request until its result enters the output register, which can stall
// synchronous active-low reset: idle, no result, all free, fit_mode 1, count 8, sizes unknown
module fixed_partition_fit_allocator
  import fpfa_pkg::*;
#(
  parameter int PARTITIONS = FPFA_PARTITIONS,
  parameter int SIZE_BITS  = FPFA_SIZE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [SLOT_W-1:0]     in_partition_slot,
  input  logic [BYTES_W-1:0]    in_partition_bytes,
  input  logic [BYTES_W-1:0]    in_request_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [SLOT_W-1:0]     out_chosen_slot,
  output logic [BYTES_W-1:0]    out_chosen_size
);

  localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_W = $clog2(PARTITIONS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [MODE_W-1:0]    fit_mode_r;
  logic [PCOUNT_W-1:0]  part_count_r;
  logic [PARTITIONS-1:0] busy_r;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     lim_r, lim_nxt;
  logic [SIZE_BITS-1:0] want_r;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 have_r, have_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [BYTES_W-1:0]   out_size_r;

  logic                 in_fire, load_fire, req_fire, load_ok;
  logic                 first_mode, issue, fits, take, commit_fire;
  logic [IDX_W-1:0]     load_addr;
  logic [SIZE_BITS-1:0] rd_data;

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign load_fire   = in_fire && (in_func == FUNC_LOAD);
  assign req_fire    = in_fire && (in_func == FUNC_REQUEST);
  assign load_ok     = 32'(in_partition_slot) < PARTITIONS;
  assign load_addr   = IDX_W'(in_partition_slot);
  assign first_mode  = (fit_mode_r == MODE_FIRST) || (fit_mode_r == MODE_RESERVED);
  assign issue       = (state_r == S_SCAN) && (idx_r < lim_r) && !(first_mode && have_r);
  assign commit_fire = (state_r == S_COMMIT) && (!out_valid_r || out_ready);

  fpfa_size_mem #(
    .DEPTH (PARTITIONS),
    .WIDTH (SIZE_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_fire && load_ok),
    .wr_addr (load_addr),
    .wr_data (SIZE_BITS'(in_partition_bytes)),
    .rd_en   (issue),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // compare stage on the size read last cycle
  always_comb begin
    fits = cmp_vld_r && !busy_r[cmp_idx_r] && (rd_data >= want_r);
    take = 1'b0;
    if (fits) begin
      priority if (!have_r) begin
        take = 1'b1;
      end else if (fit_mode_r == MODE_BEST) begin
        take = rd_data < best_r;
      end else if (fit_mode_r == MODE_WORST) begin
        take = rd_data > best_r;
      end else begin
        take = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    lim_nxt     = lim_r;
    cmp_vld_nxt = issue;
    have_nxt    = have_r;
    pick_nxt    = pick_r;
    best_nxt    = best_r;
    if (take) begin
      have_nxt = 1'b1;
      pick_nxt = cmp_idx_r;
      best_nxt = rd_data;
    end
    unique case (state_r)
      S_IDLE: begin
        if (req_fire) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
          have_nxt  = 1'b0;
          if (32'(part_count_r) > PARTITIONS) begin
            lim_nxt = CNT_W'(PARTITIONS);
          end else begin
            lim_nxt = CNT_W'(part_count_r);
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fit_mode_r   <= FIT_MODE_RESET;
      part_count_r <= PART_COUNT_RESET;
      busy_r       <= '0;
      cmp_vld_r    <= 1'b0;
      have_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FIT_MODE:   fit_mode_r   <= cfg_data[MODE_W-1:0];
          CFG_PART_COUNT: part_count_r <= cfg_data[PCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (load_fire && load_ok) begin
        busy_r[load_addr] <= 1'b0;
      end
      if (commit_fire && have_r) begin
        busy_r[pick_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    lim_r     <= lim_nxt;
    pick_r    <= pick_nxt;
    best_r    <= best_nxt;
    cmp_idx_r <= idx_r[IDX_W-1:0];
    if (req_fire) begin
      want_r <= SIZE_BITS'(in_request_size);
    end
    if (commit_fire) begin
      out_found_r <= have_r;
      out_slot_r  <= have_r ? SLOT_W'(pick_r) : '0;
      out_size_r  <= have_r ? BYTES_W'(best_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_chosen_slot = out_slot_r;
  assign out_chosen_size = out_size_r;

endmodule

### hw/rtl/fpfa_size_mem.sv
// partition size memory, one write port and one registered read port
module fpfa_size_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/fpfa_checker.sv
// port-level checks for the fixed partition fit allocator and their bind
module fpfa_checker
  import fpfa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_func,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_found,
  input logic [SLOT_W-1:0]     out_chosen_slot,
  input logic [BYTES_W-1:0]    out_chosen_size
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_chosen_slot == '0) && (out_chosen_size == '0))
    else $error("miss result carries nonzero slot or size");

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_REQUEST) |=> !in_ready)
    else $error("ready stayed high after a request item");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_LOAD) |=> in_ready)
    else $error("ready dropped after a load item");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (.*);
